// ===== rtl/rdpf_pkg.sv =====
// shared types, codes and character tables for the remote debug packet framer
// no dependencies
package rdpf_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BADSUM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;

    // framing characters
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_QUERY  = 8'h3f;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_PAYLOAD = 5'b00010,
        PH_HIGH    = 5'b00100,
        PH_LOW     = 5'b01000,
        PH_DROP    = 5'b10000
    } t_phase;

    // kind of result run being sent
    typedef enum logic [1:0] {
        RUN_STOP    = 2'd0,
        RUN_EMPTY   = 2'd1,
        RUN_BADSUM  = 2'd2,
        RUN_INVALID = 2'd3
    } t_run;

    // decoded hex digit
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_value(input logic [BYTE_W-1:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h41 + 8'd10);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // index of the final word of each run
    function automatic logic [IDX_W-1:0] run_last_idx(input t_run run);
        logic [IDX_W-1:0] n;
        case (run)
            RUN_STOP:  n = 3'd7;
            RUN_EMPTY: n = 3'd4;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [KIND_W-1:0] run_kind(input t_run run);
        logic [KIND_W-1:0] k;
        case (run)
            RUN_BADSUM:  k = KIND_BADSUM;
            RUN_INVALID: k = KIND_INVALID;
            default:     k = KIND_REPLY;
        endcase
        return k;
    endfunction

    // "+$S05#b8" and "+$#00"
    function automatic logic [BYTE_W-1:0] run_char(input t_run run,
                                                   input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        c = 8'h00;
        case (run)
            RUN_STOP: begin
                case (idx)
                    3'd0:    c = CH_PLUS;
                    3'd1:    c = CH_DOLLAR;
                    3'd2:    c = 8'h53;
                    3'd3:    c = 8'h30;
                    3'd4:    c = 8'h35;
                    3'd5:    c = CH_HASH;
                    3'd6:    c = 8'h62;
                    default: c = 8'h38;
                endcase
            end
            RUN_EMPTY: begin
                case (idx)
                    3'd0:    c = CH_PLUS;
                    3'd1:    c = CH_DOLLAR;
                    3'd2:    c = CH_HASH;
                    default: c = 8'h30;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/rdpf_if.sv =====
// valid/ready channel interfaces for the framer's byte input and result output
// depends on rdpf_pkg
interface rdpf_in_if;
    logic                         valid;
    logic                         ready;
    logic [rdpf_pkg::BYTE_W-1:0]  rx_byte;
    logic                         chunk_end;

    modport source (output valid, output rx_byte, output chunk_end, input ready);
    modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface rdpf_out_if;
    logic                         valid;
    logic                         ready;
    logic [rdpf_pkg::KIND_W-1:0]  kind;
    logic [rdpf_pkg::BYTE_W-1:0]  reply_byte;
    logic                         last_of_run;

    modport source (output valid, output kind, output reply_byte, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input reply_byte, input last_of_run,
                    output ready);
endinterface

// ===== rtl/remote_debug_packet_framer_unit.sv =====
// latency: a run-starting byte's first result word is valid the cycle after the byte is taken
// throughput: one byte per cycle; the low checksum digit or any idle-phase byte waits
//   until the current run has its last word taken; a run is 1, 5 or 8 words
//   at one word per cycle while o_tx.ready is high, set by the output run counter
// reset: synchronous active-low i_rst_n returns the parser to idle, clears the
//   sum and flags, and empties the output run register
module remote_debug_packet_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdpf_in_if.sink     i_rx,
    rdpf_out_if.source  o_tx
);

    // parser state
    rdpf_pkg::t_phase                r_phase, n_phase;
    logic [rdpf_pkg::BYTE_W-1:0]     r_sum, n_sum;
    logic [1:0]                      r_count, n_count;
    logic                            r_query, n_query;
    logic [3:0]                      r_high, n_high;
    logic                            r_high_ok, n_high_ok;

    // output run register
    logic                            r_busy, n_busy;
    rdpf_pkg::t_run                  r_run, n_run;
    logic [rdpf_pkg::IDX_W-1:0]      r_idx, n_idx;

    logic            in_take;
    logic            out_take;
    logic            out_last;
    logic            start_run;
    rdpf_pkg::t_run  start_kind;
    rdpf_pkg::t_hex  hex;

    assign hex      = rdpf_pkg::hex_value(i_rx.rx_byte);
    assign out_last = (r_idx == rdpf_pkg::run_last_idx(r_run));
    assign out_take = o_tx.valid && o_tx.ready;
    assign in_take  = i_rx.valid && i_rx.ready;

    // payload, high digit and drop phases never make words, so they pass
    // bytes even while a run drains; others wait for a free run register
    always_comb begin
        i_rx.ready = !r_busy || (out_take && out_last);
        if (r_phase == rdpf_pkg::PH_PAYLOAD || r_phase == rdpf_pkg::PH_HIGH ||
            r_phase == rdpf_pkg::PH_DROP) begin
            i_rx.ready = 1'b1;
        end
    end

    // per-byte parse
    always_comb begin
        n_phase    = r_phase;
        n_sum      = r_sum;
        n_count    = r_count;
        n_query    = r_query;
        n_high     = r_high;
        n_high_ok  = r_high_ok;
        start_run  = 1'b0;
        start_kind = rdpf_pkg::RUN_INVALID;
        if (in_take) begin
            unique case (r_phase)
                rdpf_pkg::PH_PAYLOAD: begin
                    if (i_rx.rx_byte == rdpf_pkg::CH_HASH) begin
                        n_phase = rdpf_pkg::PH_HIGH;
                    end else begin
                        n_sum = r_sum + i_rx.rx_byte;
                        if (r_count == 2'd0) begin
                            n_query = (i_rx.rx_byte == rdpf_pkg::CH_QUERY);
                        end
                        if (r_count != 2'd2) begin
                            n_count = r_count + 2'd1;
                        end
                    end
                end
                rdpf_pkg::PH_HIGH: begin
                    n_high_ok = hex.valid;
                    n_high    = hex.value;
                    n_phase   = rdpf_pkg::PH_LOW;
                end
                rdpf_pkg::PH_LOW: begin
                    n_phase   = rdpf_pkg::PH_IDLE;
                    start_run = 1'b1;
                    if (!(hex.valid && r_high_ok && {r_high, hex.value} == r_sum)) begin
                        start_kind = rdpf_pkg::RUN_BADSUM;
                    end else if (r_count == 2'd1 && r_query) begin
                        start_kind = rdpf_pkg::RUN_STOP;
                    end else begin
                        start_kind = rdpf_pkg::RUN_EMPTY;
                    end
                end
                rdpf_pkg::PH_DROP: begin
                    if (i_rx.chunk_end) begin
                        n_phase = rdpf_pkg::PH_IDLE;
                    end
                end
                default: begin
                    // idle: skip acks, open on dollar, otherwise flag and drop
                    if (i_rx.rx_byte == rdpf_pkg::CH_PLUS) begin
                        n_phase = rdpf_pkg::PH_IDLE;
                    end else if (i_rx.rx_byte == rdpf_pkg::CH_DOLLAR) begin
                        n_phase   = rdpf_pkg::PH_PAYLOAD;
                        n_sum     = '0;
                        n_count   = 2'd0;
                        n_query   = 1'b0;
                        n_high    = 4'd0;
                        n_high_ok = 1'b0;
                    end else begin
                        n_phase    = i_rx.chunk_end ? rdpf_pkg::PH_IDLE
                                                    : rdpf_pkg::PH_DROP;
                        start_run  = 1'b1;
                        start_kind = rdpf_pkg::RUN_INVALID;
                    end
                end
            endcase
        end
    end

    // run sequencing: a new run only loads when the register is free or
    // its last word leaves this cycle
    always_comb begin
        n_busy = r_busy;
        n_run  = r_run;
        n_idx  = r_idx;
        if (out_take) begin
            if (out_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (start_run) begin
            n_busy = 1'b1;
            n_run  = start_kind;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rdpf_pkg::PH_IDLE;
            r_sum     <= '0;
            r_count   <= 2'd0;
            r_query   <= 1'b0;
            r_high    <= 4'd0;
            r_high_ok <= 1'b0;
            r_busy    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_query   <= n_query;
            r_high    <= n_high;
            r_high_ok <= n_high_ok;
            r_busy    <= n_busy;
        end
    end

    // run payload needs no reset
    always_ff @(posedge i_clk) begin
        r_run <= n_run;
        r_idx <= n_idx;
    end

    // result word from the run register through the reply tables
    assign o_tx.valid       = r_busy;
    assign o_tx.kind        = rdpf_pkg::run_kind(r_run);
    assign o_tx.reply_byte  = rdpf_pkg::run_char(r_run, r_idx);
    assign o_tx.last_of_run = out_last;

endmodule
